[rtl/audio_jitter_buffer_control_defines.svh]
// assertion macros for the jitter buffer playout controller
`ifndef AUDIO_JITTER_BUFFER_CONTROL_DEFINES_SVH
`define AUDIO_JITTER_BUFFER_CONTROL_DEFINES_SVH

`ifndef ASSERT_OFF
`define AJB_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ajb assertion failed");
`define AJB_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ajb assertion failed");
`else
`define AJB_ASSERT_IMP(label, pre, post)
`define AJB_ASSERT_NXT(label, pre, post)
`endif

`endif

[rtl/ajb_pkg.sv]
package ajb_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QOUT_W      = 6;
    localparam int CNT_W       = (QCNT_W > QOUT_W) ? QCNT_W : QOUT_W;

    localparam int SAMP_W     = 48;
    localparam int PROD_W     = 58;
    localparam int RATE_W     = 18;
    localparam int BYTES_W    = 14;
    localparam int CHAN_W     = 4;
    localparam int MISS_W     = 8;
    localparam int TIME_W     = 32;
    localparam int DIVCNT_W   = 6;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DIVCNT_W-1:0] LEN_BYTES = DIVCNT_W'(BYTES_W);
    localparam logic [DIVCNT_W-1:0] LEN_TIME  = DIVCNT_W'(PROD_W);
    localparam logic [SAMP_W-1:0]   SAMP_MAX  = '1;
    localparam logic [MISS_W-1:0]   MISS_MAX  = '1;

    typedef enum logic [1:0] {
        CMD_ARRIVE  = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_START   = 2'd2,
        CMD_STOP    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_IS_16BIT     = 3'd0,
        REG_CHANNEL_COUNT       = 3'd1,
        REG_SAMPLE_RATE         = 3'd2,
        REG_MUTE_ON             = 3'd3,
        REG_VOLUME_LEVEL        = 3'd4,
        REG_PREBUFFER_THRESHOLD = 3'd5,
        REG_MISS_LIMIT          = 3'd6,
        REG_DEVICE_ACQUIRED     = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BSTART,
        S_BWAIT,
        S_ADD,
        S_MUL1,
        S_MUL2,
        S_TSTART,
        S_TWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              sample_is_16bit;
        logic [CHAN_W-1:0] channel_count;
        logic [RATE_W-1:0] sample_rate;
        logic              mute_on;
        logic [6:0]        volume_level;
        logic [5:0]        prebuffer_threshold;
        logic [MISS_W-1:0] miss_limit;
        logic              device_acquired;
    } t_cfg;

    typedef struct packed {
        logic                start;
        logic [DIVCNT_W-1:0] len;
    } t_div_req;

    typedef struct packed {
        logic              take_packet;
        logic              output_silence;
        logic              buffering_started;
        logic              buffering_stopped;
        logic              end_of_media;
        logic [TIME_W-1:0] time_ms;
        logic [QOUT_W-1:0] queue_count;
        logic              overflow_drop;
        logic              packets_wanted;
        logic              is_playing;
        logic              is_buffering;
    } t_result;

endpackage

[rtl/ajb_serial_div.sv]
module ajb_serial_div
    import ajb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [RATE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [DIVCNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]   r_num;
    logic [RATE_W-1:0]   r_den;
    logic [RATE_W-1:0]   r_rem;
    logic [PROD_W-1:0]   r_quo;

    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   trial_sub;
    logic              fits;
    logic [RATE_W-1:0] n_rem;

    // restoring division, one quotient bit a cycle, dividend enters msb first
    always_comb begin
        trial     = {r_rem, r_num[PROD_W-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = (trial >= {1'b0, r_den});
        n_rem     = fits ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIVCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/ajb_core.sv]
module ajb_core
    import ajb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [BYTES_W-1:0] i_request_bytes,
    output t_div_req           o_div_req,
    output logic [PROD_W-1:0]  o_div_dividend,
    output logic [RATE_W-1:0]  o_div_divisor,
    input  logic               i_div_done,
    input  logic [PROD_W-1:0]  i_div_quotient,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_result
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_pc;
    logic               r_play;
    logic               r_buf;
    logic [MISS_W-1:0]  r_miss;
    logic [SAMP_W-1:0]  r_samples;
    logic [BYTES_W-1:0] r_bytes;
    logic [PROD_W-1:0]  r_prod;
    t_result            r_res;
    logic               r_out_valid;
    t_result            r_out;

    logic [CNT_W-1:0]   n_pc;
    logic               n_play;
    logic               n_buf;
    logic [MISS_W-1:0]  n_miss;
    logic [MISS_W-1:0]  miss_inc;
    t_result            step_res;
    logic               step_add;
    logic               in_ready;
    logic               accept;
    logic               out_free;
    logic [BYTES_W-1:0] add_val;
    logic [SAMP_W:0]    samp_sum;
    logic [TIME_W-1:0]  time_sat;
    t_result            out_res;

    assign accept   = i_in_valid && in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // queue count and flags for one transaction
    always_comb begin
        n_pc     = r_pc;
        n_play   = r_play;
        n_buf    = r_buf;
        n_miss   = r_miss;
        miss_inc = (r_miss != MISS_MAX) ? r_miss + 1'b1 : r_miss;
        step_res = '0;
        step_add = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_ARRIVE: begin
                if (r_pc >= CNT_W'(QUEUE_DEPTH)) begin
                    step_res.overflow_drop = 1'b1;
                end else begin
                    n_pc   = r_pc + 1'b1;
                    n_miss = '0;
                    if (r_buf && (n_pc >= CNT_W'(i_cfg.prebuffer_threshold))) begin
                        n_buf                      = 1'b0;
                        step_res.buffering_stopped = 1'b1;
                    end
                end
            end
            CMD_REQUEST: begin
                step_add = r_play;
                if ((r_pc != '0) && r_play && !r_buf) begin
                    step_res.take_packet    = 1'b1;
                    n_pc                    = r_pc - 1'b1;
                    step_res.output_silence = i_cfg.mute_on || (i_cfg.volume_level == '0);
                end else begin
                    step_res.output_silence = 1'b1;
                    if (r_play) begin
                        if (!r_buf) begin
                            n_buf                      = 1'b1;
                            step_res.buffering_started = 1'b1;
                        end
                        n_miss = miss_inc;
                        if (miss_inc >= i_cfg.miss_limit) begin
                            step_res.end_of_media = 1'b1;
                            n_play                = 1'b0;
                        end
                    end
                end
            end
            CMD_START: begin
                n_play = 1'b1;
            end
            CMD_STOP: begin
                n_play = 1'b0;
            end
            default: begin
                n_play = r_play;
            end
        endcase
        step_res.queue_count    = n_pc[QOUT_W-1:0];
        step_res.packets_wanted = i_cfg.device_acquired || n_buf;
        step_res.is_playing     = n_play;
        step_res.is_buffering   = n_buf;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = step_add ? S_BSTART : S_MUL1;
            S_BSTART: n_state = S_BWAIT;
            S_BWAIT:  if (i_div_done) n_state = S_ADD;
            S_ADD:    n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_TSTART;
            S_TSTART: n_state = S_TWAIT;
            S_TWAIT:  if (i_div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready        = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.len   = LEN_TIME;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_BSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.len   = LEN_BYTES;
            end
            S_TSTART: begin
                o_div_req.start = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_BSTART) begin
            o_div_dividend = {r_bytes, (PROD_W - BYTES_W)'(0)};
            o_div_divisor  = (i_cfg.channel_count == '0) ? RATE_W'(1)
                                                         : RATE_W'(i_cfg.channel_count);
        end else begin
            o_div_dividend = r_prod;
            o_div_divisor  = (i_cfg.sample_rate == '0) ? RATE_W'(1) : i_cfg.sample_rate;
        end
    end

    always_comb begin
        add_val  = i_cfg.sample_is_16bit ? (i_div_quotient[BYTES_W-1:0] >> 1)
                                         : i_div_quotient[BYTES_W-1:0];
        samp_sum = {1'b0, r_samples} + (SAMP_W + 1)'(add_val);
        time_sat = (|i_div_quotient[PROD_W-1:TIME_W]) ? '1 : i_div_quotient[TIME_W-1:0];
        out_res         = r_res;
        out_res.time_ms = time_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_play      <= 1'b0;
            r_buf       <= 1'b1;
            r_miss      <= '0;
            r_samples   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pc   <= n_pc;
                r_play <= n_play;
                r_buf  <= n_buf;
                r_miss <= n_miss;
            end
            if (r_state == S_ADD) begin
                r_samples <= samp_sum[SAMP_W] ? SAMP_MAX : samp_sum[SAMP_W-1:0];
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // samples * 1000 as (s << 10) - (s << 4) - (s << 3), one subtract a cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res   <= step_res;
            r_bytes <= i_request_bytes;
        end
        if (r_state == S_MUL1) begin
            r_prod <= {r_samples, 10'b0} - PROD_W'({r_samples, 4'b0});
        end else if (r_state == S_MUL2) begin
            r_prod <= r_prod - PROD_W'({r_samples, 3'b0});
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= out_res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[rtl/audio_jitter_buffer_control.sv]
// one transaction in flight at a time; the shared bit-serial divider computes time_ms
// (58 bits) for every event and the per-request sample step (14 bits) for a playout
// request while playing; the result register frees the input side while it waits.
// reset (synchronous, active low) loads register defaults, empties the queue count,
// clears playback and sets buffering.
`include "audio_jitter_buffer_control_defines.svh"

module audio_jitter_buffer_control
    import ajb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [BYTES_W-1:0]    i_request_bytes,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_take_packet,
    output logic                  o_output_silence,
    output logic                  o_buffering_started,
    output logic                  o_buffering_stopped,
    output logic                  o_end_of_media,
    output logic [TIME_W-1:0]     o_time_ms,
    output logic [QOUT_W-1:0]     o_queue_count,
    output logic                  o_overflow_drop,
    output logic                  o_packets_wanted,
    output logic                  o_is_playing,
    output logic                  o_is_buffering
);

    t_cfg              r_cfg;
    t_div_req          div_req;
    logic [PROD_W-1:0] div_dividend;
    logic [RATE_W-1:0] div_divisor;
    logic              div_done;
    logic [PROD_W-1:0] div_quotient;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_is_16bit     <= 1'b1;
            r_cfg.channel_count       <= CHAN_W'(1);
            r_cfg.sample_rate         <= RATE_W'(44100);
            r_cfg.mute_on             <= 1'b0;
            r_cfg.volume_level        <= 7'd100;
            r_cfg.prebuffer_threshold <= 6'd20;
            r_cfg.miss_limit          <= MISS_W'(40);
            r_cfg.device_acquired     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SAMPLE_IS_16BIT:     r_cfg.sample_is_16bit     <= i_cfg_data[0];
                REG_CHANNEL_COUNT:       r_cfg.channel_count       <= i_cfg_data[CHAN_W-1:0];
                REG_SAMPLE_RATE:         r_cfg.sample_rate         <= i_cfg_data[RATE_W-1:0];
                REG_MUTE_ON:             r_cfg.mute_on             <= i_cfg_data[0];
                REG_VOLUME_LEVEL:        r_cfg.volume_level        <= i_cfg_data[6:0];
                REG_PREBUFFER_THRESHOLD: r_cfg.prebuffer_threshold <= i_cfg_data[5:0];
                REG_MISS_LIMIT:          r_cfg.miss_limit          <= i_cfg_data[MISS_W-1:0];
                REG_DEVICE_ACQUIRED:     r_cfg.device_acquired     <= i_cfg_data[0];
                default:                 r_cfg                     <= r_cfg;
            endcase
        end
    end

    ajb_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_request_bytes (i_request_bytes),
        .o_div_req       (div_req),
        .o_div_dividend  (div_dividend),
        .o_div_divisor   (div_divisor),
        .i_div_done      (div_done),
        .i_div_quotient  (div_quotient),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (result)
    );

    ajb_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign o_take_packet       = result.take_packet;
    assign o_output_silence    = result.output_silence;
    assign o_buffering_started = result.buffering_started;
    assign o_buffering_stopped = result.buffering_stopped;
    assign o_end_of_media      = result.end_of_media;
    assign o_time_ms           = result.time_ms;
    assign o_queue_count       = result.queue_count;
    assign o_overflow_drop     = result.overflow_drop;
    assign o_packets_wanted    = result.packets_wanted;
    assign o_is_playing        = result.is_playing;
    assign o_is_buffering      = result.is_buffering;

    `AJB_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `AJB_ASSERT_IMP(a_eom_stops, o_out_valid && o_end_of_media, !o_is_playing)
    `AJB_ASSERT_IMP(a_bstart_buffers, o_out_valid && o_buffering_started, o_is_buffering)
    `AJB_ASSERT_IMP(a_take_not_drop, o_out_valid && o_take_packet,
                    !o_overflow_drop && !o_buffering_started && !o_end_of_media)

endmodule
